// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/utf8dec_pkg.sv =====
// Types and constants shared by the UTF-8 to UCS-2 decoder modules.
`default_nettype none
package utf8dec_pkg;

  localparam logic [15:0] SUBST_CHAR = 16'd63;

  // One decoded input byte: a run of '?' results, then an optional value.
  typedef struct packed {
    logic [1:0]  sub_n;
    logic        val_en;
    logic [15:0] val;
  } job_t;

  // Queue status seen by the back part and the top level.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/utf8dec_front.sv =====
// Front part: classify each byte, track sequence state, build one job per byte.
`default_nettype none
module utf8dec_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_fire,
  input  wire  [7:0]        in_byte,
  input  wire               in_last,
  output utf8dec_pkg::job_t job,
  output logic              job_push
);
  import utf8dec_pkg::*;

  logic [15:0] pv_r, pv_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [2:0]  skip_r, skip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      held_r <= '0;
      len_r  <= '0;
      skip_r <= '0;
    end else if (in_fire) begin
      pv_r   <= pv_nxt;
      held_r <= held_nxt;
      len_r  <= len_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_comb begin
    logic        do_lead;
    logic        lead_sub;
    logic [2:0]  sub_cnt;
    logic [15:0] cont_v;

    pv_nxt   = pv_r;
    held_nxt = held_r;
    len_nxt  = len_r;
    skip_nxt = skip_r;
    do_lead  = 1'b0;
    lead_sub = 1'b0;
    sub_cnt  = '0;
    cont_v   = pv_r | {10'd0, in_byte[5:0]};
    job      = '0;

    if (skip_r != 3'd0) begin
      skip_nxt = skip_r - 3'd1;
    end else if (held_r == 2'd0) begin
      do_lead = 1'b1;
    end else if (in_byte[7:6] == 2'b10) begin
      if (len_r == 2'd3 && held_r == 2'd1) begin
        pv_nxt   = pv_r | {4'd0, in_byte[5:0], 6'd0};
        held_nxt = 2'd2;
      end else begin
        pv_nxt     = '0;
        held_nxt   = '0;
        len_nxt    = '0;
        job.val    = cont_v;
        job.val_en = (cont_v != 16'd0);
      end
    end else begin
      // Bad continuation: flush held bytes, then restart on this byte.
      sub_cnt  = {1'b0, held_r};
      pv_nxt   = '0;
      held_nxt = '0;
      len_nxt  = '0;
      do_lead  = 1'b1;
    end

    if (do_lead) begin
      if (in_byte[7] == 1'b0) begin
        job.val    = {8'd0, in_byte};
        job.val_en = (in_byte != 8'd0);
      end else if (in_byte[7:5] == 3'b110) begin
        pv_nxt   = {5'd0, in_byte[4:0], 6'd0};
        held_nxt = 2'd1;
        len_nxt  = 2'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
        pv_nxt   = {in_byte[3:0], 12'd0};
        held_nxt = 2'd1;
        len_nxt  = 2'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
        lead_sub = 1'b1;
        skip_nxt = 3'd3;
      end else if (in_byte[7:2] == 6'b111110) begin
        lead_sub = 1'b1;
        skip_nxt = 3'd4;
      end else if (in_byte[7:1] == 7'b1111110) begin
        lead_sub = 1'b1;
        skip_nxt = 3'd5;
      end else begin
        lead_sub = 1'b1;
      end
    end

    sub_cnt = sub_cnt + {2'd0, lead_sub};

    // End of stream: flush whatever is still held and drop any skip.
    if (in_last) begin
      sub_cnt  = sub_cnt + {1'b0, held_nxt};
      pv_nxt   = '0;
      held_nxt = '0;
      len_nxt  = '0;
      skip_nxt = '0;
    end

    job.sub_n = (sub_cnt > 3'd3) ? 2'd3 : sub_cnt[1:0];
    job_push  = in_fire && (job.sub_n != 2'd0 || job.val_en);
  end

endmodule
`default_nettype wire

// ===== hdl/utf8dec_queue.sv =====
// Job queue between the front and back parts.
`default_nettype none
module utf8dec_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  utf8dec_pkg::job_t      push_job,
  input  wire                    pop,
  output utf8dec_pkg::job_t      head_job,
  output utf8dec_pkg::q_stat_t   stat
);
  import utf8dec_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full      = (count_r == CW'(QUEUE_DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign head_job       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8dec_back.sv =====
// Back part: expand each job into results through a registered output stage.
`default_nettype none
module utf8dec_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  utf8dec_pkg::job_t      head_job,
  input  utf8dec_pkg::q_stat_t   stat,
  output logic                   pop,
  input  wire                    out_ready,
  output logic                   out_valid,
  output logic [15:0]            out_unit,
  output logic                   out_subst,
  output logic                   out_last
);
  import utf8dec_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        subst_r, subst_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  idx_r, idx_nxt;

  assign out_valid = valid_r;
  assign out_unit  = unit_r;
  assign out_subst = subst_r;
  assign out_last  = last_r;

  always_comb begin
    logic load;
    logic is_last;

    load      = !valid_r || out_ready;
    valid_nxt = valid_r;
    unit_nxt  = unit_r;
    subst_nxt = subst_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    is_last   = 1'b0;

    if (load) begin
      valid_nxt = stat.not_empty;
      if (stat.not_empty) begin
        if (idx_r < head_job.sub_n) begin
          unit_nxt  = SUBST_CHAR;
          subst_nxt = 1'b1;
          is_last   = (idx_r + 2'd1 == head_job.sub_n) && !head_job.val_en;
        end else begin
          unit_nxt  = head_job.val;
          subst_nxt = 1'b0;
          is_last   = 1'b1;
        end
        last_nxt = is_last;
        pop      = is_last;
        idx_nxt  = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r  <= unit_nxt;
    subst_r <= subst_nxt;
    last_r  <= last_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/utf8_to_ucs2_checked_decoder_unit.sv =====
// Top level of the checked UTF-8 to UCS-2 decoder.
//
//   channel   dir   payload                                  transfer when
//   in_*      in    in_tdata[7:0] byte, in_tlast end mark     in_tvalid & in_tready
//   out_*     out   out_tdata code unit, out_tuser '?' flag,  out_tvalid & out_tready
//                   out_tlast last result of its byte
//
// One byte is taken per cycle while the job queue has room; the front part decodes
// it in that same cycle into a job of up to three results and pushes the job into
// the job queue if it holds any. The back part drains one result per cycle through
// its output register while out_tready is high; bytes with no result push no job.
// in_tready drops only while the job queue is full; out_tready stalls only the back.
// Reset (rst_n low, synchronous) clears the sequence state, the queue and out_tvalid.
`default_nettype none
module utf8_to_ucs2_checked_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] in_byte
  input  wire         in_tlast,   // stream_end
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tuser,  // [0] substituted
  output logic        out_tlast   // run_last
);
  import utf8dec_pkg::*;

  job_t    new_job;
  job_t    head_job;
  q_stat_t q_stat;
  logic    job_push;
  logic    job_pop;
  logic    in_fire;

  // Accept a byte whenever the queue has room for its job.
  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;

  utf8dec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .job      (new_job),
    .job_push (job_push)
  );

  utf8dec_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (new_job),
    .pop      (job_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  utf8dec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .stat      (q_stat),
    .pop       (job_pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_unit  (out_tdata),
    .out_subst (out_tuser),
    .out_last  (out_tlast)
  );

`include "assert_macros.svh"

  // A flagged result always carries the replacement character.
  `ASSERT_SAME(a_subst_is_q, clk, rst_n, out_tvalid && out_tuser, out_tdata == SUBST_CHAR)
  // Decoded zeros are dropped, so a plain result is never zero.
  `ASSERT_SAME(a_no_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata != 16'd0)
  // A full queue means the back part has a result waiting.
  `ASSERT_NEXT(a_full_drains, clk, rst_n, !in_tready, out_tvalid)

endmodule
`default_nettype wire

// ===== sim/tb_utf8_to_ucs2_checked_decoder_unit.sv =====
// Self-checking testbench for the checked UTF-8 to UCS-2 decoder unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_utf8_to_ucs2_checked_decoder_unit;
  import utf8dec_pkg::*;

  // One byte of the UTF-8 stream, with its end-of-stream mark.
  typedef struct {
    logic [7:0] b;
    logic       fin;
  } utf8_byte_t;

  // One expected UCS-2 result.
  typedef struct {
    logic [15:0] cu;
    logic        subst;
    logic        last;
  } ucs2_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] in_byte
  logic        in_tlast = 1'b0;   // stream_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] code_unit
  logic        out_tuser;         // [0] substituted
  logic        out_tlast;         // run_last

  // Bytes waiting to be offered, and UCS-2 results still owed by the block.
  utf8_byte_t  pend_q[$];
  ucs2_res_t   ucs2_expect_q[$];
  ucs2_res_t   run_q[$];

  // Predictor state: a held multi-byte sequence and the skip count of long leads.
  logic [15:0] part_val = '0;
  logic [1:0]  held_cnt = '0;
  logic [1:0]  seq_len = '0;
  logic [2:0]  skip_cnt = '0;

  // Transfers seen at the last rising edge, for the falling-edge drivers.
  logic        in_xfer = 1'b0;
  logic        out_xfer = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          n_err = 0;

  utf8_to_ucs2_checked_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Append one result to the run of the current byte; a byte yields three at most,
  // so any result past the third is dropped.
  task automatic push_unit(input logic [15:0] cu, input logic subst);
    ucs2_res_t r;
    r.cu = cu;
    r.subst = subst;
    r.last = 1'b0;
    if (run_q.size() < 3)
      run_q.push_back(r);
  endtask

  // A decoded zero never leaves the block.
  task automatic push_value(input logic [15:0] v);
    if (v != 16'h0000)
      push_unit(v, 1'b0);
  endtask

  task automatic clear_seq();
    part_val = '0;
    held_cnt = '0;
    seq_len = '0;
  endtask

  // Decode b as the first byte of a new sequence.
  task automatic take_lead(input logic [7:0] b);
    casez (b)
      8'b0???????: push_value({8'h00, b});
      8'b110?????: begin
        part_val = {5'b0, b[4:0], 6'b0};
        held_cnt = 2'd1;
        seq_len = 2'd2;
      end
      8'b1110????: begin
        part_val = {b[3:0], 12'b0};
        held_cnt = 2'd1;
        seq_len = 2'd3;
      end
      8'b11110???: begin
        push_unit(SUBST_CHAR, 1'b1);
        skip_cnt = 3'd3;
      end
      8'b111110??: begin
        push_unit(SUBST_CHAR, 1'b1);
        skip_cnt = 3'd4;
      end
      8'b1111110?: begin
        push_unit(SUBST_CHAR, 1'b1);
        skip_cnt = 3'd5;
      end
      // stray continuation byte, 0xFE, 0xFF
      default: push_unit(SUBST_CHAR, 1'b1);
    endcase
  endtask

  // Work out the UCS-2 results of one accepted byte and queue them up.
  task automatic predict_ucs2_units(input logic [7:0] b, input logic fin);
    int          n_held;
    logic [15:0] v;
    run_q.delete();
    if (skip_cnt != 0) begin
      skip_cnt = skip_cnt - 3'd1;
    end else if (held_cnt == 0) begin
      take_lead(b);
    end else if (b[7:6] == 2'b10) begin
      if (seq_len == 2'd3 && held_cnt == 2'd1) begin
        part_val = part_val | {4'b0, b[5:0], 6'b0};
        held_cnt = 2'd2;
      end else begin
        v = part_val | {10'b0, b[5:0]};
        clear_seq();
        push_value(v);
      end
    end else begin
      // Broken sequence: '?' per held byte, then start over with this byte.
      n_held = held_cnt;
      clear_seq();
      repeat (n_held) push_unit(SUBST_CHAR, 1'b1);
      take_lead(b);
    end
    if (fin) begin
      n_held = held_cnt;
      repeat (n_held) push_unit(SUBST_CHAR, 1'b1);
      clear_seq();
      skip_cnt = '0;
    end
    if (run_q.size() != 0)
      run_q[$].last = 1'b1;
    foreach (run_q[i])
      ucs2_expect_q.push_back(run_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic fin);
    utf8_byte_t it;
    it.b = b;
    it.fin = fin;
    pend_q.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: change at the falling edge, hold the byte until its transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feed
    utf8_byte_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pend_q.size() != 0) begin
        it = pend_q.pop_front();
        in_tdata <= it.b;
        in_tlast <= it.fin;
        in_tvalid <= 1'b1;
        // Now and then flip between idling and back-to-back bytes.
        if ($urandom_range(0, 31) == 0)
          in_calm = !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: draw a stall after every result transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drain
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall = out_stall;
      if (out_xfer) begin
        if ($urandom_range(0, 31) == 0)
          out_calm = !out_calm;
        stall = out_calm ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        out_stall <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each byte transfer, then check each result transfer
  // against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    ucs2_res_t want;
    if (!rst_n) begin
      in_xfer <= 1'b0;
      out_xfer <= 1'b0;
    end else begin
      in_xfer <= in_tvalid && in_tready;
      out_xfer <= out_tvalid && out_tready;
      if (in_tvalid && in_tready)
        predict_ucs2_units(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (ucs2_expect_q.size() == 0) begin
          $error("unexpected result: code_unit %04h substituted %0b run_last %0b",
                 out_tdata, out_tuser, out_tlast);
          n_err++;
        end else begin
          want = ucs2_expect_q.pop_front();
          if (out_tdata !== want.cu) begin
            $error("code_unit: expected %04h, got %04h", want.cu, out_tdata);
            n_err++;
          end
          if (out_tuser !== want.subst) begin
            $error("substituted: expected %0b, got %0b", want.subst, out_tuser);
            n_err++;
          end
          if (out_tlast !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, out_tlast);
            n_err++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the byte queue, release reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin : run
    int          n_rand;
    int          k;
    logic        fin;
    logic [15:0] cp;
    logic [7:0]  lead;

    // Directed: plain ASCII and a dropped zero.
    add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b0);
    // Two-byte form, three-byte form, three-byte form of zero.
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    // Stray continuation and the invalid leads.
    add_byte(8'h80, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'hFF, 1'b0);
    // Long leads; the end mark cuts the skip short.
    add_byte(8'hF7, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hC3, 1'b1);
    add_byte(8'hFD, 1'b0);
    add_byte(8'h7F, 1'b1);
    // Bad second byte, then bad third byte.
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'h41, 1'b0);
    // Lead held at stream end; full sequence broken by a lead that ends the stream.
    add_byte(8'hDF, 1'b1);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hC2, 1'b1);

    // Random: mostly well-formed sequences with random content, some noise.
    n_rand = 0;
    while (n_rand < 152) begin
      fin = ($urandom_range(0, 11) == 0);
      cp = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1: begin
          add_byte({1'b0, cp[6:0]}, fin);
          n_rand += 1;
        end
        2, 3: begin
          add_byte({3'b110, cp[10:6]}, 1'b0);
          add_byte({2'b10, cp[5:0]}, fin);
          n_rand += 2;
        end
        4, 5: begin
          add_byte({4'b1110, cp[15:12]}, 1'b0);
          add_byte({2'b10, cp[11:6]}, 1'b0);
          add_byte({2'b10, cp[5:0]}, fin);
          n_rand += 3;
        end
        6: begin
          // Four- to six-byte lead and its unchecked tail.
          k = $urandom_range(3, 5);
          case (k)
            3:       lead = {5'b11110, cp[2:0]};
            4:       lead = {6'b111110, cp[1:0]};
            default: lead = {7'b1111110, cp[0]};
          endcase
          add_byte(lead, 1'b0);
          repeat (k - 1) add_byte(8'($urandom), 1'b0);
          add_byte(8'($urandom), fin);
          n_rand += k + 1;
        end
        7: begin
          // Truncated sequence: the next byte breaks it, or the end mark does.
          if (cp[0]) begin
            add_byte({4'b1110, cp[15:12]}, 1'b0);
            add_byte({2'b10, cp[11:6]}, fin);
            n_rand += 2;
          end else begin
            add_byte({3'b110, cp[10:6]}, fin);
            n_rand += 1;
          end
        end
        8: begin
          add_byte(8'($urandom_range(0, 255)), fin);
          n_rand += 1;
        end
        default: begin
          add_byte({2'b10, cp[5:0]}, fin);
          n_rand += 1;
        end
      endcase
    end

    // Hold reset, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes transferred, every result in, then spare cycles
    // to catch anything extra the block may still push out.
    @(negedge clk);
    while (pend_q.size() != 0 || in_tvalid) @(negedge clk);
    while (ucs2_expect_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/utf8dec_pkg.sv
hdl/utf8dec_front.sv
hdl/utf8dec_queue.sv
hdl/utf8dec_back.sv
hdl/utf8_to_ucs2_checked_decoder_unit.sv
sim/tb_utf8_to_ucs2_checked_decoder_unit.sv
